// File: design/sha1bsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher package
// Shared types, round constants and the initial hash vector.
// ----------------------------------------------------------------------------
package sha1bsh_pkg;

   localparam int WORD_W      = 32;
   localparam int BLOCK_BYTES = 64;
   localparam int BLOCK_W     = BLOCK_BYTES * 8;
   localparam int ROUNDS      = 80;
   localparam int ROUND_W     = 7;
   localparam int DIGEST_WORDS = 5;
   localparam int INDEX_W     = 3;

   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

   localparam logic [1:0] PHASE_CH  = 2'd0;
   localparam logic [1:0] PHASE_P1  = 2'd1;
   localparam logic [1:0] PHASE_MAJ = 2'd2;
   localparam logic [1:0] PHASE_P2  = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
      logic [WORD_W-1:0] e;
   } work_type;

   localparam work_type INIT_VEC = '{
      a: 32'h67452301,
      b: 32'hefcdab89,
      c: 32'h98badcfe,
      d: 32'h10325476,
      e: 32'hc3d2e1f0
   };

   function automatic logic [WORD_W-1:0] round_const(input logic [1:0] phase);
      logic [WORD_W-1:0] k;
      case (phase)
         PHASE_CH:  k = 32'h5a827999;
         PHASE_P1:  k = 32'h6ed9eba1;
         PHASE_MAJ: k = 32'h8f1bbcdc;
         default:   k = 32'hca62c1d6;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

// File: design/sha1bsh_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 request channel
// Valid/ready channel carrying one message byte or a finish command.
// ----------------------------------------------------------------------------
interface sha1bsh_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface
`default_nettype wire

// File: design/sha1bsh_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 response channel
// Valid/ready channel carrying one 32-bit digest word per beat.
// ----------------------------------------------------------------------------
interface sha1bsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface
`default_nettype wire

// File: design/sha1bsh_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round: selects the boolean function and constant for the
// round index and produces the next working variables.
// ----------------------------------------------------------------------------
module sha1bsh_round (
   input  wire sha1bsh_pkg::work_type                cur,
   input  wire logic [sha1bsh_pkg::WORD_W-1:0]       w,
   input  wire logic [sha1bsh_pkg::ROUND_W-1:0]      round_idx,
   output sha1bsh_pkg::work_type                     nxt
);

   logic [1:0]                    phase;
   logic [sha1bsh_pkg::WORD_W-1:0] f;
   logic [sha1bsh_pkg::WORD_W-1:0] temp;

   always_comb begin
      if (round_idx < 7'd20) begin
         phase = sha1bsh_pkg::PHASE_CH;
      end else if (round_idx < 7'd40) begin
         phase = sha1bsh_pkg::PHASE_P1;
      end else if (round_idx < 7'd60) begin
         phase = sha1bsh_pkg::PHASE_MAJ;
      end else begin
         phase = sha1bsh_pkg::PHASE_P2;
      end
   end

   always_comb begin
      case (phase)
         sha1bsh_pkg::PHASE_CH:  f = (cur.b & cur.c) ^ (~cur.b & cur.d);
         sha1bsh_pkg::PHASE_MAJ: f = (cur.b & cur.c) ^ (cur.b & cur.d) ^ (cur.c & cur.d);
         default:                f = cur.b ^ cur.c ^ cur.d;
      endcase
   end

   assign temp = {cur.a[26:0], cur.a[31:27]} + f + cur.e
               + sha1bsh_pkg::round_const(phase) + w;

   assign nxt.a = temp;
   assign nxt.b = cur.a;
   assign nxt.c = {cur.b[1:0], cur.b[31:2]};
   assign nxt.d = cur.c;
   assign nxt.e = cur.d;

endmodule
`default_nettype wire

// File: design/sha1_byte_stream_hasher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Hashes a byte stream with SHA-1 and returns the 160-bit digest as five
// words on a finish command.
//
//   channel  dir  beat
//   req_ch   in   one message byte (req_type 0) or finish (req_type 1)
//   rsp_ch   out  one digest word, index 0..4, last_word on index 4
//
// The 64th byte of a block starts a compression (80 rounds through the
// single round unit, then the add). A finish appends the padding (9 to 72
// bytes), runs one or two compressions, then returns five response beats.
// req_ch.ready is low while compressing, padding or returning the digest.
// Synchronous reset loads the initial vector and clears the byte count.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_top (
   input  wire logic    clock,
   input  wire logic    reset,
   sha1bsh_req_if.sink   req_ch,
   sha1bsh_rsp_if.source rsp_ch
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   localparam logic [1:0] PAD_MARK = 2'd0;
   localparam logic [1:0] PAD_ZERO = 2'd1;
   localparam logic [1:0] PAD_LEN  = 2'd2;

   localparam int TOP = sha1bsh_pkg::BLOCK_W - 1;

   logic [2:0]                             state_ff, state_in;
   logic [63:0]                            count_ff, count_in;
   logic [63:0]                            bits_ff, bits_in;
   logic [TOP:0]                           buf_ff, buf_in;
   sha1bsh_pkg::work_type                  chain_ff, chain_in;
   sha1bsh_pkg::work_type                  work_ff, work_in;
   sha1bsh_pkg::work_type                  round_out;
   logic [sha1bsh_pkg::ROUND_W-1:0]        round_ff, round_in;
   logic [sha1bsh_pkg::INDEX_W-1:0]        idx_ff, idx_in;
   logic [1:0]                             pad_kind_ff, pad_kind_in;
   logic [2:0]                             len_cnt_ff, len_cnt_in;
   logic                                   fin_ff, fin_in;
   logic                                   done_ff, done_in;
   logic                                   append_en;
   logic [7:0]                             app_byte;
   logic [sha1bsh_pkg::WORD_W-1:0]         sched_word;
   logic [63:0]                            count_inc;

   assign req_ch.ready = (state_ff == ST_IDLE);

   assign sched_word = {buf_ff[TOP-416 -: 32] ^ buf_ff[TOP-256 -: 32]
                        ^ buf_ff[TOP-64 -: 32] ^ buf_ff[TOP -: 32]}
                       << 1
                       | {31'd0, buf_ff[TOP-416-0] ^ buf_ff[TOP-256-0]
                                 ^ buf_ff[TOP-64-0] ^ buf_ff[TOP]};

   assign count_inc = count_ff + 64'd1;

   sha1bsh_round u_round (
      .cur       (work_ff),
      .w         (buf_ff[TOP -: 32]),
      .round_idx (round_ff),
      .nxt       (round_out)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      bits_in     = bits_ff;
      buf_in      = buf_ff;
      chain_in    = chain_ff;
      work_in     = work_ff;
      round_in    = round_ff;
      idx_in      = idx_ff;
      pad_kind_in = pad_kind_ff;
      len_cnt_in  = len_cnt_ff;
      fin_in      = fin_ff;
      done_in     = done_ff;
      append_en   = 1'b0;
      app_byte    = 8'h00;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.req_type == sha1bsh_pkg::REQ_FINISH) begin
                  bits_in     = {count_ff[60:0], 3'b000};
                  fin_in      = 1'b1;
                  done_in     = 1'b0;
                  len_cnt_in  = 3'd0;
                  pad_kind_in = PAD_MARK;
                  state_in    = ST_PAD;
               end else begin
                  append_en = 1'b1;
                  app_byte  = req_ch.data_byte;
               end
            end
         end
         ST_PAD: begin
            append_en = 1'b1;
            case (pad_kind_ff)
               PAD_MARK: app_byte = sha1bsh_pkg::PAD_MARK_BYTE;
               PAD_ZERO: app_byte = 8'h00;
               default: begin
                  app_byte   = bits_ff[63:56];
                  bits_in    = {bits_ff[55:0], 8'h00};
                  len_cnt_in = len_cnt_ff + 3'd1;
                  if (len_cnt_ff == 3'd7) begin
                     done_in = 1'b1;
                  end
               end
            endcase
            if (pad_kind_ff != PAD_LEN) begin
               if (count_inc[5:0] == 6'd56) begin
                  pad_kind_in = PAD_LEN;
               end else begin
                  pad_kind_in = PAD_ZERO;
               end
            end
         end
         ST_ROUND: begin
            work_in  = round_out;
            buf_in   = {buf_ff[TOP-32:0], sched_word};
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(sha1bsh_pkg::ROUNDS - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in.a = chain_ff.a + work_ff.a;
            chain_in.b = chain_ff.b + work_ff.b;
            chain_in.c = chain_ff.c + work_ff.c;
            chain_in.d = chain_ff.d + work_ff.d;
            chain_in.e = chain_ff.e + work_ff.e;
            if (fin_ff && done_ff) begin
               idx_in   = '0;
               state_in = ST_OUT;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               if (idx_ff == 3'(sha1bsh_pkg::DIGEST_WORDS - 1)) begin
                  chain_in = sha1bsh_pkg::INIT_VEC;
                  count_in = '0;
                  fin_in   = 1'b0;
                  done_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (append_en) begin
         buf_in   = {buf_ff[TOP-8:0], app_byte};
         count_in = count_inc;
         if (count_ff[5:0] == 6'd63) begin
            work_in  = chain_ff;
            round_in = '0;
            state_in = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         chain_ff    <= sha1bsh_pkg::INIT_VEC;
         round_ff    <= '0;
         idx_ff      <= '0;
         pad_kind_ff <= PAD_MARK;
         len_cnt_ff  <= '0;
         fin_ff      <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         chain_ff    <= chain_in;
         round_ff    <= round_in;
         idx_ff      <= idx_in;
         pad_kind_ff <= pad_kind_in;
         len_cnt_ff  <= len_cnt_in;
         fin_ff      <= fin_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      buf_ff  <= buf_in;
      work_ff <= work_in;
   end

   always_comb begin
      case (idx_ff)
         3'd0:    rsp_ch.digest_word = chain_ff.a;
         3'd1:    rsp_ch.digest_word = chain_ff.b;
         3'd2:    rsp_ch.digest_word = chain_ff.c;
         3'd3:    rsp_ch.digest_word = chain_ff.d;
         default: rsp_ch.digest_word = chain_ff.e;
      endcase
   end

   assign rsp_ch.valid      = (state_ff == ST_OUT);
   assign rsp_ch.word_index = idx_ff;
   assign rsp_ch.last_word  = (idx_ff == 3'(sha1bsh_pkg::DIGEST_WORDS - 1));

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("response beat while request channel open");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff < 7'(sha1bsh_pkg::ROUNDS)))
      else $error("round index out of range");

   a_block_full: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_ROUND) |-> (count_ff[5:0] == 6'd0))
      else $error("compression started on a partial block");

   a_digest_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last_word)
      |=> (count_ff == 64'd0) && req_ch.ready)
      else $error("hasher not restarted after digest");

   a_pad_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && fin_ff && done_ff) |-> (count_ff[5:0] == 6'd0))
      else $error("padding ended off a block boundary");
`endif

endmodule
`default_nettype wire
